// File: rtl/core/sbo_pkg.sv
// sbo_pkg: constants, types and layout functions for the seg-y byte order converter
// no dependencies; imported by segy_byte_order_converter_top
package sbo_pkg;

    localparam int TEXT_BYTES   = 3200;
    localparam int BIN_BYTES    = 400;
    localparam int BIN_W4_FIRST = 3;
    localparam int BIN_W2       = 24;
    localparam int TRACE_BYTES  = 240;
    localparam int COUNT_BYTE   = 114;
    localparam int SAMPLE_RESET = 4096;
    localparam int TR_FIELDS    = 11;

    localparam int POS_W   = 12;
    localparam int LEFT_W  = 17;
    localparam int MAX_W   = 15;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 2;

    // result queue: one input may leave up to five items
    localparam int MAX_RES = 5;
    localparam int Q_DEPTH = 16;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // trace header layout: run lengths and word sizes
    localparam int TR_CNT [TR_FIELDS] = '{7, 4, 8, 2, 4, 46, 6, 2, 2, 2, 5};
    localparam int TR_SZ  [TR_FIELDS] = '{4, 2, 4, 2, 4, 2, 4, 2, 4, 2, 4};

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_FORMAT_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FOREIGN_ORDER = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_SAMPLES   = 2'd2;

    // format modes
    localparam logic [MODE_W-1:0] MODE_GRID    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HDRONLY = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_COUNT     = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    typedef enum logic [5:0] {
        SEC_TEXT    = 6'b000001,
        SEC_BIN     = 6'b000010,
        SEC_TRHDR   = 6'b000100,
        SEC_DATA    = 6'b001000,
        SEC_GRID    = 6'b010000,
        SEC_HDRONLY = 6'b100000
    } t_section;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] error_code;
        logic       last;
    } t_item;

    function automatic t_section start_section(input logic [MODE_W-1:0] mode);
        t_section s;
        if (mode == MODE_FULL) begin
            s = SEC_TEXT;
        end else if (mode == MODE_HDRONLY) begin
            s = SEC_HDRONLY;
        end else begin
            s = SEC_GRID;
        end
        return s;
    endfunction

    // 1 where the trace header byte belongs to a 4-byte word
    function automatic logic trace_is_w4(input logic [POS_W-1:0] pos);
        int   base;
        logic w4;
        logic found;
        base  = 0;
        w4    = 1'b1;
        found = 1'b0;
        for (int i = 0; i < TR_FIELDS; i++) begin
            if (!found && pos < POS_W'(base + TR_CNT[i] * TR_SZ[i])) begin
                w4    = (TR_SZ[i] == 4);
                found = 1'b1;
            end
            base = base + TR_CNT[i] * TR_SZ[i];
        end
        return w4;
    endfunction

    function automatic logic bin_is_w4(input logic [POS_W-1:0] pos);
        return (pos < POS_W'(BIN_W4_FIRST * 4)) || (pos >= POS_W'(BIN_W4_FIRST * 4 + BIN_W2 * 2));
    endfunction

endpackage

// File: rtl/core/segy_byte_order_converter_top.sv
// segy_byte_order_converter_top: byte-order conversion of a seg-y or grid byte stream
// depends on sbo_pkg for layout tables, section codes and the result item type
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata = data_byte, tlast = end_of_file
//  m_axis    out  tvalid/tready           tdata = out_byte, tuser = error_code, tlast = last
//  cfg       in   i_cfg_we (no wait)      i_cfg_idx, i_cfg_wdata
//
// one input byte is taken per cycle while s_axis_tready is high; its results are written
// to a 16-entry item queue in the same edge and leave from there one per cycle while
// m_axis_tready is high; a word's output bytes leave after the items already queued
// s_axis_tready is high while the queue has room for five more items
// reset (synchronous, active low) empties the queue and restarts in full seg-y mode
module segy_byte_order_converter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]                  m_axis_tuser,   // [1:0] error_code
    output logic                        m_axis_tlast,
    input  logic                        i_cfg_we,
    input  logic [sbo_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [sbo_pkg::MAX_W-1:0]   i_cfg_wdata
);
    import sbo_pkg::*;

    // configuration
    logic [MODE_W-1:0] r_mode;
    logic              r_foreign;
    logic [MAX_W-1:0]  r_max;

    // stream state
    t_section          r_section, n_section;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [23:0]       r_held, n_held;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_halted, n_halted;

    // item queue
    t_item             r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    logic              s_acc, m_acc;
    logic [7:0]        b;
    logic              eof;

    // word assembly
    logic              tk_en, tk_sz4, tk_swap, tk_done;
    logic [1:0]        tk_off;
    logic [23:0]       tk_held;
    logic [7:0]        tk_bytes [4];

    // results of this input
    logic [7:0]        d_bytes [4];
    logic [2:0]        d_n;
    logic              err_en;
    logic [1:0]        err_code;
    logic [2:0]        total;
    t_item             items [Q_DEPTH];

    logic [15:0]       raw_cnt;
    logic [LEFT_W-1:0] left_dec;

    assign b     = s_axis_tdata;
    assign eof   = s_axis_tlast;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_count <= QCNT_W'(Q_DEPTH - MAX_RES));
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_q[r_rd_ptr].out_byte;
    assign m_axis_tuser  = r_q[r_rd_ptr].error_code;
    assign m_axis_tlast  = r_q[r_rd_ptr].last;

    assign raw_cnt  = r_foreign ? {r_held[7:0], b} : {b, r_held[7:0]};
    assign left_dec = (r_left != '0) ? r_left - LEFT_W'(1) : r_left;

    // word size, byte offset and swap for this byte
    always_comb begin
        tk_en   = 1'b0;
        tk_sz4  = 1'b1;
        tk_off  = 2'd0;
        tk_swap = 1'b1;
        unique case (r_section)
            SEC_TEXT: begin
                tk_en = 1'b0;
            end
            SEC_BIN: begin
                tk_en  = 1'b1;
                tk_sz4 = bin_is_w4(r_pos);
            end
            SEC_TRHDR: begin
                tk_en  = 1'b1;
                tk_sz4 = trace_is_w4(r_pos);
            end
            SEC_DATA: begin
                tk_en = 1'b1;
            end
            SEC_HDRONLY: begin
                tk_en   = 1'b1;
                tk_sz4  = trace_is_w4(r_pos);
                tk_swap = r_foreign;
            end
            default: begin
                tk_en = 1'b1;
            end
        endcase
        if (r_section == SEC_DATA) begin
            tk_off = 2'd0 - r_left[1:0];
        end else if (tk_sz4) begin
            tk_off = r_pos[1:0];
        end else begin
            tk_off = {1'b0, r_pos[0]};
        end
        tk_done = tk_en && (tk_off == (tk_sz4 ? 2'd3 : 2'd1));
        if (!tk_en) begin
            tk_held = r_held;
        end else if (tk_done) begin
            tk_held = '0;
        end else begin
            tk_held = {r_held[15:0], b};
        end
        // output order of the finished word
        if (tk_sz4) begin
            if (tk_swap) begin
                tk_bytes = '{b, r_held[7:0], r_held[15:8], r_held[23:16]};
            end else begin
                tk_bytes = '{r_held[23:16], r_held[15:8], r_held[7:0], b};
            end
        end else begin
            if (tk_swap) begin
                tk_bytes = '{b, r_held[7:0], 8'd0, 8'd0};
            end else begin
                tk_bytes = '{r_held[7:0], b, 8'd0, 8'd0};
            end
        end
    end

    // next state and results of one accepted byte
    always_comb begin
        n_section = r_section;
        n_pos     = r_pos;
        n_held    = tk_held;
        n_left    = r_left;
        n_halted  = r_halted;
        d_bytes   = tk_bytes;
        d_n       = tk_done ? (tk_sz4 ? 3'd4 : 3'd2) : 3'd0;
        err_en    = 1'b0;
        err_code  = ERR_NONE;

        unique case (r_section)
            SEC_TEXT: begin
                d_bytes[0] = b;
                d_n        = 3'd1;
                n_pos      = r_pos + POS_W'(1);
                if (r_pos == POS_W'(TEXT_BYTES - 1)) begin
                    n_section = SEC_BIN;
                    n_pos     = '0;
                end
                if (eof) begin
                    err_en   = 1'b1;
                    err_code = ERR_TRUNCATED;
                end
            end
            SEC_BIN: begin
                n_pos = r_pos + POS_W'(1);
                if (r_pos == POS_W'(BIN_BYTES - 1)) begin
                    n_section = SEC_TRHDR;
                    n_pos     = '0;
                end else if (eof) begin
                    err_en   = 1'b1;
                    err_code = ERR_TRUNCATED;
                end
            end
            SEC_TRHDR: begin
                n_pos = r_pos + POS_W'(1);
                if (r_pos == POS_W'(COUNT_BYTE + 1)) begin
                    if (raw_cnt[15] || (raw_cnt[14:0] > r_max)) begin
                        err_en   = 1'b1;
                        err_code = ERR_COUNT;
                        n_pos    = r_pos;
                    end else begin
                        n_left = LEFT_W'({raw_cnt[14:0], 2'b00});
                    end
                end else if (r_pos == POS_W'(TRACE_BYTES - 1)) begin
                    n_pos     = '0;
                    n_section = (r_left != '0) ? SEC_DATA : SEC_TRHDR;
                    if (eof && (r_left != '0)) begin
                        err_en   = 1'b1;
                        err_code = ERR_TRUNCATED;
                    end
                end
            end
            SEC_DATA: begin
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_section = SEC_TRHDR;
                    n_pos     = '0;
                end else if (eof) begin
                    err_en   = 1'b1;
                    err_code = ERR_TRUNCATED;
                end
            end
            SEC_HDRONLY: begin
                n_pos = (r_pos == POS_W'(TRACE_BYTES - 1)) ? '0 : r_pos + POS_W'(1);
            end
            default: begin
                n_pos = {{(POS_W-2){1'b0}}, r_pos[1:0] + 2'd1};
            end
        endcase

        if (err_en) begin
            n_halted = 1'b1;
        end else if (eof) begin
            n_section = start_section(r_mode);
            n_pos     = '0;
            n_held    = '0;
            n_left    = '0;
            n_halted  = 1'b0;
        end

        if (r_halted) begin
            d_n       = 3'd0;
            err_en    = 1'b0;
            n_section = r_section;
            n_pos     = r_pos;
            n_held    = r_held;
            n_left    = r_left;
            n_halted  = r_halted;
        end

        total = d_n + {2'b00, err_en};
        for (int k = 0; k < Q_DEPTH; k++) begin
            if (k < 4 && 3'(k) < d_n) begin
                items[k].out_byte   = d_bytes[k[1:0]];
                items[k].error_code = ERR_NONE;
            end else begin
                items[k].out_byte   = 8'd0;
                items[k].error_code = err_code;
            end
            items[k].last = (3'(k) == total - 3'd1);
        end
    end

    always_comb begin
        n_count = r_count;
        if (s_acc) begin
            n_count = n_count + QCNT_W'(total);
        end
        if (m_acc) begin
            n_count = n_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_FULL;
            r_foreign <= 1'b1;
            r_max     <= MAX_W'(SAMPLE_RESET);
            r_section <= SEC_TEXT;
            r_pos     <= '0;
            r_held    <= '0;
            r_left    <= '0;
            r_halted  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_FORMAT_MODE) begin
                // a mode write restarts the stream
                r_mode    <= i_cfg_wdata[MODE_W-1:0];
                r_section <= start_section(i_cfg_wdata[MODE_W-1:0]);
                r_pos     <= '0;
                r_held    <= '0;
                r_left    <= '0;
                r_halted  <= 1'b0;
            end else if (i_cfg_idx == CFG_FOREIGN_ORDER) begin
                r_foreign <= i_cfg_wdata[0];
            end else if (i_cfg_idx == CFG_MAX_SAMPLES) begin
                r_max <= i_cfg_wdata;
            end
        end else if (s_acc) begin
            r_section <= n_section;
            r_pos     <= n_pos;
            r_held    <= n_held;
            r_left    <= n_left;
            r_halted  <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_acc) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(total);
            end
            if (m_acc) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // each queue slot takes the item whose offset from the write pointer it holds
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < Q_DEPTH; j++) begin
            logic [QPTR_W-1:0] offs;
            offs = QPTR_W'(j) - r_wr_ptr;
            if (s_acc && (offs < QPTR_W'(total))) begin
                r_q[j] <= items[offs];
            end
        end
    end

endmodule

// File: tb/tb_segy_byte_order_converter_top.sv
// tb_segy_byte_order_converter_top: self-checking bench for the seg-y byte order converter
// needs sbo_pkg and segy_byte_order_converter_top; a scoreboard class predicts every output item
// from the bytes accepted, random bursts and stalls drive both stream ports
module tb_segy_byte_order_converter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbo_pkg::*;

    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 8;
    localparam int TXT_LEN           = 3200;
    localparam int BIN_LEN           = 400;
    localparam int HDR_LEN           = 240;
    localparam int CNT_POS           = 114;
    localparam int COUNT_LIMIT_RESET = 4096;
    localparam int QUIET_CYCLES      = 4;
    localparam int DRAIN_CYCLES      = 20;
    localparam int HOLD_START        = 2000;
    localparam int HOLD_LEN          = 400;
    localparam int RANDOM_ITEMS      = 330;
    localparam int CYCLE_LIMIT       = 2_000_000;

    // mode value 3 is not named by the block, it runs as grid mode
    localparam logic [MODE_W-1:0] MODE_GRID_ALT = 2'd3;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;   // [7:0] data_byte
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // [7:0] out_byte
    logic [1:0]        m_axis_tuser;         // [1:0] error_code
    logic              m_axis_tlast;
    logic              i_cfg_we      = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx     = '0;
    logic [MAX_W-1:0]  i_cfg_wdata   = '0;

    segy_byte_order_converter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    class swap_scoreboard;
        logic [MODE_W-1:0] mode;
        logic              big_endian;
        logic [MAX_W-1:0]  count_limit;
        t_section          sec;
        logic [11:0]       pos;
        logic [23:0]       pending;
        logic [16:0]       samples_left;
        logic              stopped;
        t_item             step_out[$];
        t_item             bytes_due[$];
        int                fails;

        function new();
            mode        = MODE_FULL;
            big_endian  = 1'b1;
            count_limit = MAX_W'(COUNT_LIMIT_RESET);
            fails       = 0;
            restart_file();
        endfunction

        function void restart_file();
            if (mode == MODE_FULL) begin
                sec = SEC_TEXT;
            end else if (mode == MODE_HDRONLY) begin
                sec = SEC_HDRONLY;
            end else begin
                sec = SEC_GRID;
            end
            pos          = '0;
            pending      = '0;
            samples_left = '0;
            stopped      = 1'b0;
        endfunction

        function void apply_write(logic [IDX_W-1:0] idx, logic [MAX_W-1:0] value);
            case (idx)
                CFG_FORMAT_MODE: begin
                    mode = value[MODE_W-1:0];
                    restart_file();
                end
                CFG_FOREIGN_ORDER: big_endian = value[0];
                CFG_MAX_SAMPLES: count_limit = value;
                default: ;
            endcase
        endfunction

        // trace header: 2-byte runs sit between 4-byte runs
        function int hdr_word_bytes(logic [11:0] p);
            if ((p >= 28 && p < 36) || (p >= 68 && p < 72) || (p >= 88 && p < 180) ||
                (p >= 204 && p < 208) || (p >= 216 && p < 220)) begin
                return 2;
            end
            return 4;
        endfunction

        function int bin_word_bytes(logic [11:0] p);
            if (p >= 12 && p < 60) begin
                return 2;
            end
            return 4;
        endfunction

        function void put(logic [7:0] value, logic [1:0] code);
            t_item it;
            it.out_byte   = value;
            it.error_code = code;
            it.last       = 1'b0;
            step_out.push_back(it);
        endfunction

        function void halt(logic [1:0] code);
            put(8'h00, code);
            stopped = 1'b1;
        endfunction

        // gathers a word, oldest byte highest; the complete word leaves at once
        function void take(logic [7:0] b, int size, int off, logic swap);
            logic [7:0] w [4];
            if (off + 1 < size) begin
                pending = {pending[15:0], b};
                return;
            end
            if (size == 4) begin
                w[0] = pending[23:16];
                w[1] = pending[15:8];
                w[2] = pending[7:0];
                w[3] = b;
            end else begin
                w[0] = pending[7:0];
                w[1] = b;
            end
            for (int i = 0; i < size; i++) begin
                put(swap ? w[size - 1 - i] : w[i], ERR_NONE);
            end
            pending = '0;
        endfunction

        function void take_input_byte(logic [7:0] b, logic eof);
            int          sz;
            logic        err;
            logic [7:0]  lead_byte;
            logic        cnt_word;
            logic [15:0] raw;
            t_item       it;
            step_out.delete();
            err = 1'b0;
            if (stopped) begin
                return;
            end
            case (sec)
                SEC_TEXT: begin
                    put(b, ERR_NONE);
                    pos++;
                    if (pos >= TXT_LEN) begin
                        sec = SEC_BIN;
                        pos = '0;
                    end
                    if (eof) begin
                        halt(ERR_TRUNCATED);
                        err = 1'b1;
                    end
                end
                SEC_BIN: begin
                    sz = bin_word_bytes(pos);
                    take(b, sz, int'(pos) & (sz - 1), 1'b1);
                    pos++;
                    if (pos >= BIN_LEN) begin
                        sec = SEC_TRHDR;
                        pos = '0;
                    end else if (eof) begin
                        halt(ERR_TRUNCATED);
                        err = 1'b1;
                    end
                end
                SEC_TRHDR: begin
                    lead_byte = pending[7:0];
                    cnt_word  = (pos == CNT_POS + 1);
                    sz        = hdr_word_bytes(pos);
                    take(b, sz, int'(pos) & (sz - 1), 1'b1);
                    if (cnt_word) begin
                        raw = big_endian ? {lead_byte, b} : {b, lead_byte};
                        // count bytes go out first, then the error item
                        if (raw[15] || raw > count_limit) begin
                            halt(ERR_COUNT);
                            err = 1'b1;
                        end else begin
                            samples_left = {raw[14:0], 2'b00};
                        end
                    end
                    if (!err) begin
                        pos++;
                        if (pos >= HDR_LEN) begin
                            pos = '0;
                            sec = (samples_left != 0) ? SEC_DATA : SEC_TRHDR;
                            if (eof && samples_left != 0) begin
                                halt(ERR_TRUNCATED);
                                err = 1'b1;
                            end
                        end
                    end
                end
                SEC_DATA: begin
                    take(b, 4, (0 - int'(samples_left)) & 3, 1'b1);
                    if (samples_left != 0) begin
                        samples_left--;
                    end
                    if (samples_left == 0) begin
                        sec = SEC_TRHDR;
                        pos = '0;
                    end else if (eof) begin
                        halt(ERR_TRUNCATED);
                        err = 1'b1;
                    end
                end
                SEC_HDRONLY: begin
                    sz = hdr_word_bytes(pos);
                    take(b, sz, int'(pos) & (sz - 1), big_endian);
                    pos++;
                    if (pos >= HDR_LEN) begin
                        pos = '0;
                    end
                end
                default: begin
                    take(b, 4, int'(pos) & 3, 1'b1);
                    pos = (pos + 1) & 12'd3;
                end
            endcase
            if (eof && !err) begin
                restart_file();
            end
            foreach (step_out[i]) begin
                it      = step_out[i];
                it.last = (i == step_out.size() - 1);
                bytes_due.push_back(it);
            end
        endfunction

        function void check_output_byte(logic [7:0] got_byte, logic [1:0] got_code,
                                        logic got_last);
            t_item want;
            if (bytes_due.size() == 0) begin
                fails++;
                $display("%0t: unexpected item, expected none, actual byte %h code %0d last %b",
                         $time, got_byte, got_code, got_last);
                return;
            end
            want = bytes_due.pop_front();
            if (want.out_byte !== got_byte) begin
                fails++;
                $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got_byte);
            end
            if (want.error_code !== got_code) begin
                fails++;
                $display("%0t: error_code expected %0d actual %0d",
                         $time, want.error_code, got_code);
            end
            if (want.last !== got_last) begin
                fails++;
                $display("%0t: last expected %b actual %b", $time, want.last, got_last);
            end
        endfunction
    endclass

    swap_scoreboard sb;
    logic [7:0]     file_bytes[$];
    int             burst_left = 0;
    int             cycles;
    int             rx_cycle;
    int             rx_phase_left;
    int             rx_style;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver: phases of steady, random and sparse ready, plus one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_cycle      = 0;
            rx_phase_left = 0;
            rx_style      = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_output_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            rx_cycle++;
            if (rx_phase_left == 0) begin
                rx_style      = $urandom_range(0, 2);
                rx_phase_left = $urandom_range(10, 200);
            end
            rx_phase_left--;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = (gap == 0) ? $urandom_range(20, 200) : $urandom_range(1, 40);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.take_input_byte(b, eof);
        burst_left--;
    endtask

    // the last byte of each file carries the end-of-file mark
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_item(file_bytes[i], i == file_bytes.size() - 1);
        end
        file_bytes.delete();
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (sb.bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MAX_W-1:0] value);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.apply_write(idx, value);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void push_random(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endfunction

    // first n bytes of a trace header with the sample count in the current order
    function automatic void push_header(input logic [15:0] cnt, input int n);
        logic [7:0] hdr [HDR_LEN];
        for (int i = 0; i < HDR_LEN; i++) begin
            hdr[i] = 8'($urandom);
        end
        if (sb.big_endian) begin
            hdr[CNT_POS]     = cnt[15:8];
            hdr[CNT_POS + 1] = cnt[7:0];
        end else begin
            hdr[CNT_POS]     = cnt[7:0];
            hdr[CNT_POS + 1] = cnt[15:8];
        end
        for (int i = 0; i < n; i++) begin
            file_bytes.push_back(hdr[i]);
        end
    endfunction

    function automatic logic count_ok(input logic [15:0] cnt);
        return !cnt[15] && cnt <= sb.count_limit;
    endfunction

    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 16'($urandom_range(0, 6));
        end
        if (r == 6) begin
            return 16'($urandom);
        end
        if (r == 7) begin
            return 16'($urandom_range(32768, 65535));
        end
        if (sb.count_limit <= 64) begin
            return (r == 8) ? 16'(sb.count_limit) : 16'(sb.count_limit) + 16'd1;
        end
        return 16'($urandom_range(0, 64));
    endfunction

    function automatic logic [MAX_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 4);
        case (r)
            0: return '0;
            1: return '1;
            2: return MAX_W'($urandom_range(0, 16));
            3: return MAX_W'($urandom);
            default: return MAX_W'(COUNT_LIMIT_RESET);
        endcase
    endfunction

    // file with one to four traces, sometimes with a bad sample count, sometimes cut short
    function automatic void build_random_segy();
        int          traces;
        int          n_samp;
        int          cut;
        logic [15:0] cnt;
        push_random(TXT_LEN + BIN_LEN);
        traces = $urandom_range(1, 4);
        for (int t = 0; t < traces; t++) begin
            cnt = pick_count();
            push_header(cnt, HDR_LEN);
            if (!count_ok(cnt)) begin
                push_random($urandom_range(0, 8));
                break;
            end
            // long traces are cut inside their samples
            n_samp = (cnt > 64) ? 64 : int'(cnt);
            push_random(4 * n_samp);
            if (n_samp != cnt) begin
                break;
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, file_bytes.size() - 1);
        end else if ($urandom_range(0, 2) == 0) begin
            cut = $urandom_range(1, file_bytes.size() - TXT_LEN - BIN_LEN);
        end else begin
            cut = 0;
        end
        repeat (cut) void'(file_bytes.pop_back());
    endfunction

    initial begin
        int                rand_items;
        int                full_files;
        int                r;
        logic [MODE_W-1:0] mode_pick;

        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: full seg-y, foreign order; clean end on the last sample byte
        push_random(TXT_LEN + BIN_LEN);
        push_header(16'd2, HDR_LEN);
        push_random(8);
        push_header(16'd0, HDR_LEN);
        push_header(16'd1, HDR_LEN);
        push_random(4);
        send_file();
        // end of file early in the text header, then bytes the halted block drops
        push_random(10);
        send_file();
        push_random(6);
        send_file();
        write_reg(CFG_FORMAT_MODE, MAX_W'(MODE_FULL));
        // end of file on the last text byte
        push_random(TXT_LEN);
        send_file();
        write_reg(CFG_FORMAT_MODE, MAX_W'(MODE_FULL));
        // end of file inside the binary header
        push_random(TXT_LEN + 37);
        send_file();
        write_reg(CFG_FORMAT_MODE, MAX_W'(MODE_FULL));
        // end on the last binary header byte is clean
        push_random(TXT_LEN + BIN_LEN);
        send_file();
        // header cut just after its count word: the partial word is dropped, clean
        push_random(TXT_LEN + BIN_LEN);
        push_header(16'd0, HDR_LEN);
        push_header(16'd3, CNT_POS + 5);
        send_file();
        // file ends right after a header that announces samples
        push_random(TXT_LEN + BIN_LEN);
        push_header(16'd5, HDR_LEN);
        send_file();
        write_reg(CFG_MAX_SAMPLES, '1);
        write_reg(CFG_FORMAT_MODE, MAX_W'(MODE_FULL));
        // long trace cut inside its samples
        push_random(TXT_LEN + BIN_LEN);
        push_header(16'd300, HDR_LEN);
        push_random(1197);
        send_file();
        write_reg(CFG_FORMAT_MODE, MAX_W'(MODE_FULL));
        // negative sample count
        push_random(TXT_LEN + BIN_LEN);
        push_header(16'h8000, HDR_LEN);
        push_random(20);
        send_file();
        write_reg(CFG_FOREIGN_ORDER, MAX_W'(1'b0));
        write_reg(CFG_MAX_SAMPLES, '0);
        write_reg(CFG_FORMAT_MODE, MAX_W'(MODE_FULL));
        // little-endian count word: zero passes, one is over the limit
        push_random(TXT_LEN + BIN_LEN);
        push_header(16'd0, HDR_LEN);
        push_header(16'd1, HDR_LEN);
        push_random(8);
        send_file();
        // grid words with extreme bytes, partial word dropped at the end
        write_reg(CFG_FORMAT_MODE, MAX_W'(MODE_GRID));
        file_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA,
                       8'h12, 8'h34, 8'h56};
        send_file();
        write_reg(CFG_FORMAT_MODE, MAX_W'(MODE_GRID_ALT));
        push_random(6);
        send_file();
        // header-only: native order passes through, foreign order swaps
        write_reg(CFG_FORMAT_MODE, MAX_W'(MODE_HDRONLY));
        push_random(HDR_LEN + 5);
        send_file();
        write_reg(CFG_FOREIGN_ORDER, MAX_W'(1'b1));
        push_random(HDR_LEN + 10);
        send_file();

        rand_items = 0;
        full_files = 0;
        while (rand_items < RANDOM_ITEMS || full_files < 2) begin
            if (sb.stopped || $urandom_range(0, 2) != 0) begin
                r = $urandom_range(0, 7);
                if (r < 2) begin
                    mode_pick = MODE_FULL;
                end else if (r < 5) begin
                    mode_pick = MODE_HDRONLY;
                end else if (r < 7) begin
                    mode_pick = MODE_GRID;
                end else begin
                    mode_pick = MODE_GRID_ALT;
                end
                write_reg(CFG_FORMAT_MODE, MAX_W'(mode_pick));
                write_reg(CFG_FOREIGN_ORDER, MAX_W'($urandom_range(0, 1)));
                write_reg(CFG_MAX_SAMPLES, pick_limit());
            end
            case (sb.mode)
                MODE_FULL: begin
                    build_random_segy();
                    full_files++;
                    if (file_bytes.size() > TXT_LEN + BIN_LEN) begin
                        rand_items += file_bytes.size() - TXT_LEN - BIN_LEN;
                    end
                end
                MODE_HDRONLY: begin
                    push_random(HDR_LEN * $urandom_range(1, 2) + $urandom_range(0, 30));
                    rand_items += file_bytes.size();
                end
                default: begin
                    push_random($urandom_range(1, 60));
                    rand_items += file_bytes.size();
                end
            endcase
            send_file();
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0 && sb.bytes_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
